>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by tld_engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define TLD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tld assertion failed");

// Condition that must never be true outside reset.
`define TLD_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tld forbidden condition");

`endif

>>> hw/rtl/tld_pkg.sv
// ----------------------------------------------------------------------------
// tld_pkg
// Types and codes of the terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

	localparam logic [1:0] CMD_TYPED    = 2'd0;
	localparam logic [1:0] CMD_READ     = 2'd1;
	localparam logic [1:0] CMD_TAKE_SIG = 2'd2;
	localparam logic [1:0] CMD_TAKE_EOF = 2'd3;

	localparam logic [1:0] KIND_ECHO   = 2'd0;
	localparam logic [1:0] KIND_ERASE  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_CONSUMED   = 3'd0;
	localparam logic [2:0] ST_LINE_READY = 3'd1;
	localparam logic [2:0] ST_SIGNAL     = 3'd2;
	localparam logic [2:0] ST_EOF        = 3'd3;
	localparam logic [2:0] ST_OVERFLOW   = 3'd4;
	localparam logic [2:0] ST_BYTE_READ  = 3'd5;
	localparam logic [2:0] ST_EMPTY      = 3'd6;
	localparam logic [2:0] ST_TAKEN      = 3'd7;

	localparam logic [1:0] SIG_NONE = 2'd0;
	localparam logic [1:0] SIG_INT  = 2'd1;
	localparam logic [1:0] SIG_QUIT = 2'd2;
	localparam logic [1:0] SIG_STOP = 2'd3;

	localparam logic [2:0] REG_MODE  = 3'd0;
	localparam logic [2:0] REG_INTR  = 3'd1;
	localparam logic [2:0] REG_QUIT  = 3'd2;
	localparam logic [2:0] REG_ERASE = 3'd3;
	localparam logic [2:0] REG_KILL  = 3'd4;
	localparam logic [2:0] REG_EOF   = 3'd5;
	localparam logic [2:0] REG_SUSP  = 3'd6;

	localparam int MODE_SIG    = 0;
	localparam int MODE_CANON  = 1;
	localparam int MODE_ECHO   = 2;
	localparam int MODE_VERASE = 3;

	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [8:0] ERASE_MAX  = 9'd511;

	typedef enum logic [3:0] {
		OP_READ, OP_TAKE_SIG, OP_TAKE_EOF, OP_SIG, OP_NL, OP_EOF,
		OP_ERASE, OP_KILL, OP_APPEND, OP_RAW
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic [1:0] sig;
	} item_t;

	typedef struct packed {
		logic [3:0] mode;
		logic [7:0] intr_ch;
		logic [7:0] quit_ch;
		logic [7:0] erase_ch;
		logic [7:0] kill_ch;
		logic [7:0] eof_ch;
		logic [7:0] susp_ch;
	} cfg_t;

endpackage

>>> hw/rtl/tld_if.sv
// ----------------------------------------------------------------------------
// tld channel interfaces
// Input item, result item and register write channels.
// ----------------------------------------------------------------------------
interface tld_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] in_byte;
	modport source (output valid, cmd, in_byte, input ready);
	modport sink (input valid, cmd, in_byte, output ready);
endinterface

interface tld_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] echo_byte;
	logic [8:0] erase_count;
	logic [2:0] status;
	logic [7:0] read_byte;
	logic [1:0] signal_code;
	logic       eof_flag;
	logic       data_ready;
	logic       last;
	modport source (output valid, kind, echo_byte, erase_count, status, read_byte,
		signal_code, eof_flag, data_ready, last, input ready);
	modport sink (input valid, kind, echo_byte, erase_count, status, read_byte,
		signal_code, eof_flag, data_ready, last, output ready);
endinterface

interface tld_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [7:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/tld_regs.sv
// ----------------------------------------------------------------------------
// tld_regs
// Configuration registers; a write to registers 0..6 also requests a line state clear.
// ----------------------------------------------------------------------------
module tld_regs (
	input  logic          clk,
	input  logic          arst_n,
	tld_cfg_if.sink       cfg_ch,
	output tld_pkg::cfg_t cfg,
	output logic          clr
);
	import tld_pkg::*;

	cfg_t cfg_q;
	logic clr_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;
	assign clr = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode     <= 4'd15;
			cfg_q.intr_ch  <= 8'd3;
			cfg_q.quit_ch  <= 8'd28;
			cfg_q.erase_ch <= 8'd127;
			cfg_q.kill_ch  <= 8'h15;
			cfg_q.eof_ch   <= 8'd4;
			cfg_q.susp_ch  <= 8'd26;
			clr_q          <= 1'b0;
		end else begin
			clr_q <= 1'b0;
			if (cfg_ch.valid) begin
				clr_q <= 1'b1;
				case (cfg_ch.index)
					REG_MODE:  cfg_q.mode     <= cfg_ch.data[3:0];
					REG_INTR:  cfg_q.intr_ch  <= cfg_ch.data;
					REG_QUIT:  cfg_q.quit_ch  <= cfg_ch.data;
					REG_ERASE: cfg_q.erase_ch <= cfg_ch.data;
					REG_KILL:  cfg_q.kill_ch  <= cfg_ch.data;
					REG_EOF:   cfg_q.eof_ch   <= cfg_ch.data;
					REG_SUSP:  cfg_q.susp_ch  <= cfg_ch.data;
					default:   clr_q          <= 1'b0;
				endcase
			end
		end
	end

endmodule

>>> hw/rtl/tld_front.sv
// ----------------------------------------------------------------------------
// tld_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tld_front (
	input  logic           clk,
	input  logic           arst_n,
	tld_in_if.sink         in_ch,
	input  tld_pkg::cfg_t  cfg,
	output tld_pkg::item_t item,
	output logic           item_valid,
	input  logic           item_pop
);
	import tld_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	item_t      cls;
	logic       push;

	// Signal chars win over every other meaning of a typed byte.
	always_comb begin
		cls.data = in_ch.in_byte;
		cls.sig  = SIG_NONE;
		cls.op   = OP_RAW;
		case (in_ch.cmd)
			CMD_READ:     cls.op = OP_READ;
			CMD_TAKE_SIG: cls.op = OP_TAKE_SIG;
			CMD_TAKE_EOF: cls.op = OP_TAKE_EOF;
			default: begin
				if (cfg.mode[MODE_SIG] && (in_ch.in_byte == cfg.intr_ch ||
						in_ch.in_byte == cfg.quit_ch || in_ch.in_byte == cfg.susp_ch)) begin
					cls.op  = OP_SIG;
					cls.sig = (in_ch.in_byte == cfg.intr_ch) ? SIG_INT :
						(in_ch.in_byte == cfg.quit_ch) ? SIG_QUIT : SIG_STOP;
				end else if (cfg.mode[MODE_CANON]) begin
					if (in_ch.in_byte == CH_NEWLINE)        cls.op = OP_NL;
					else if (in_ch.in_byte == cfg.eof_ch)   cls.op = OP_EOF;
					else if (in_ch.in_byte == cfg.erase_ch) cls.op = OP_ERASE;
					else if (in_ch.in_byte == cfg.kill_ch)  cls.op = OP_KILL;
					else                                    cls.op = OP_APPEND;
				end
			end
		endcase
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign item = slot_q[rd_ptr_q];
	assign item_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (item_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, item_pop};
		end
	end

endmodule

>>> hw/rtl/tld_engine.sv
// ----------------------------------------------------------------------------
// tld_engine
// Carries out classified items: edit line, cooked ring, signal and eof state.
// ----------------------------------------------------------------------------
module tld_engine #(
	parameter int LINE_LEN    = 256,
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  tld_pkg::cfg_t  cfg,
	input  logic           clr,
	input  tld_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_pop,
	tld_out_if.source      out_ch
);
	import tld_pkg::*;
	`include "assert_macros.svh"

	localparam int LIW = $clog2(LINE_LEN);
	localparam int LLW = $clog2(LINE_LEN + 1);
	localparam int PW  = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {S_IDLE, S_COPY, S_NLPUSH, S_RDWAIT, S_STATUS} state_t;

	state_t     state_q;
	logic [7:0] line_mem [LINE_LEN];
	logic [7:0] ring_mem [QUEUE_DEPTH];
	logic [LLW-1:0] line_len_q, copy_idx_q;
	logic [PW-1:0]  head_q, tail_q, tail_inc, head_inc;
	logic       full_q, eof_q, eof0_q, nl_q, copy_pend_q;
	logic [1:0] sig_q, sig0_q;
	logic [2:0] stat_q;
	logic [7:0] rb_q, line_rd_q, ring_rd_q;
	logic       q_empty, out_free, q_we, line_we, copy_push, full_after, copy_issue;
	logic [7:0] q_wdata;
	logic [8:0] kill_cnt;

	logic       ovalid_q, olast_q, oeof_q, odr_q;
	logic [1:0] okind_q, osig_q;
	logic [7:0] oecho_q, orb_q;
	logic [8:0] ocnt_q;
	logic [2:0] ostat_q;

	assign tail_inc = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign head_inc = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign q_empty  = (head_q == tail_q) && !full_q;
	assign out_free = !ovalid_q || out_ch.ready;
	assign kill_cnt = (32'(line_len_q) > 32'(ERASE_MAX)) ? ERASE_MAX : 9'(line_len_q);

	// Copy loop: one line read issued per cycle, pushed into the ring the cycle after.
	assign copy_push  = (state_q == S_COPY) && copy_pend_q && !full_q;
	assign full_after = full_q || (copy_push && tail_inc == head_q);
	assign copy_issue = (state_q == S_COPY) && (copy_idx_q < line_len_q) && !full_after;

	assign item_pop = (state_q == S_IDLE) && item_valid && out_free;

	always_comb begin
		q_we    = 1'b0;
		q_wdata = item.data;
		line_we = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (item_pop && item.op == OP_RAW) q_we = !full_q;
				if (item_pop && item.op == OP_APPEND)
					line_we = 32'(line_len_q) < 32'(LINE_LEN);
			end
			S_COPY: begin
				q_we    = copy_push;
				q_wdata = line_rd_q;
			end
			S_NLPUSH: begin
				q_we    = !full_q;
				q_wdata = CH_NEWLINE;
			end
			default: q_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (line_we) line_mem[line_len_q[LIW-1:0]] <= item.data;
		line_rd_q <= line_mem[copy_idx_q[LIW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_we) ring_mem[tail_q] <= q_wdata;
		ring_rd_q <= ring_mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			line_len_q  <= '0;
			copy_idx_q  <= '0;
			copy_pend_q <= 1'b0;
			head_q      <= '0;
			tail_q      <= '0;
			full_q      <= 1'b0;
			sig_q       <= SIG_NONE;
			eof_q       <= 1'b0;
			nl_q        <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			if (out_ch.ready) ovalid_q <= 1'b0;
			if (q_we) begin
				tail_q <= tail_inc;
				full_q <= (tail_inc == head_q);
			end
			case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						sig0_q      <= sig_q;
						eof0_q      <= eof_q;
						rb_q        <= 8'd0;
						stat_q      <= ST_CONSUMED;
						copy_idx_q  <= '0;
						copy_pend_q <= 1'b0;
						nl_q        <= 1'b0;
						okind_q     <= KIND_ECHO;
						oecho_q     <= item.data;
						ocnt_q      <= 9'd0;
						ostat_q     <= ST_CONSUMED;
						orb_q       <= 8'd0;
						osig_q      <= SIG_NONE;
						oeof_q      <= 1'b0;
						odr_q       <= 1'b0;
						olast_q     <= 1'b0;
						state_q     <= S_STATUS;
						case (item.op)
							OP_READ: begin
								if (q_empty) stat_q <= ST_EMPTY;
								else state_q <= S_RDWAIT;
							end
							OP_TAKE_SIG: begin
								sig_q  <= SIG_NONE;
								stat_q <= ST_TAKEN;
							end
							OP_TAKE_EOF: begin
								eof_q  <= 1'b0;
								stat_q <= ST_TAKEN;
							end
							OP_SIG: begin
								sig_q  <= item.sig;
								stat_q <= ST_SIGNAL;
							end
							OP_NL: begin
								ovalid_q <= 1'b1;
								nl_q     <= 1'b1;
								stat_q   <= ST_LINE_READY;
								state_q  <= S_COPY;
							end
							OP_EOF: begin
								if (line_len_q == '0) begin
									eof_q  <= 1'b1;
									stat_q <= ST_EOF;
								end else begin
									stat_q  <= ST_LINE_READY;
									state_q <= S_COPY;
								end
							end
							OP_ERASE: begin
								if (line_len_q != '0) begin
									line_len_q <= line_len_q - 1'b1;
									okind_q    <= KIND_ERASE;
									oecho_q    <= 8'd0;
									ocnt_q     <= 9'd1;
									ovalid_q   <= cfg.mode[MODE_VERASE];
								end
							end
							OP_KILL: begin
								okind_q    <= KIND_ERASE;
								oecho_q    <= 8'd0;
								ocnt_q     <= kill_cnt;
								ovalid_q   <= (line_len_q != '0) && cfg.mode[MODE_VERASE];
								line_len_q <= '0;
							end
							OP_APPEND: begin
								if (line_we) begin
									line_len_q <= line_len_q + 1'b1;
									ovalid_q   <= cfg.mode[MODE_ECHO];
								end else begin
									stat_q <= ST_OVERFLOW;
								end
							end
							default: begin
								// raw byte
								ovalid_q <= cfg.mode[MODE_ECHO];
								stat_q   <= ST_LINE_READY;
							end
						endcase
					end
				end
				S_COPY: begin
					copy_pend_q <= copy_issue;
					if (copy_issue) begin
						copy_idx_q <= copy_idx_q + 1'b1;
					end else begin
						line_len_q <= '0;
						state_q    <= nl_q ? S_NLPUSH : S_STATUS;
					end
				end
				S_NLPUSH: state_q <= S_STATUS;
				S_RDWAIT: begin
					rb_q    <= ring_rd_q;
					head_q  <= head_inc;
					full_q  <= 1'b0;
					stat_q  <= ST_BYTE_READ;
					state_q <= S_STATUS;
				end
				S_STATUS: begin
					if (out_free) begin
						ovalid_q <= 1'b1;
						okind_q  <= KIND_STATUS;
						oecho_q  <= 8'd0;
						ocnt_q   <= 9'd0;
						ostat_q  <= stat_q;
						orb_q    <= rb_q;
						osig_q   <= sig0_q;
						oeof_q   <= eof0_q;
						odr_q    <= !q_empty || eof_q;
						olast_q  <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (clr) begin
				line_len_q <= '0;
				sig_q      <= SIG_NONE;
				eof_q      <= 1'b0;
			end
		end
	end

	assign out_ch.valid       = ovalid_q;
	assign out_ch.kind        = okind_q;
	assign out_ch.echo_byte   = oecho_q;
	assign out_ch.erase_count = ocnt_q;
	assign out_ch.status      = ostat_q;
	assign out_ch.read_byte   = orb_q;
	assign out_ch.signal_code = osig_q;
	assign out_ch.eof_flag    = oeof_q;
	assign out_ch.data_ready  = odr_q;
	assign out_ch.last        = olast_q;

	`TLD_ASSERT(a_full_ptrs, clk, arst_n, full_q |-> (head_q == tail_q))
	`TLD_NEVER(a_line_bound, clk, arst_n, 32'(line_len_q) > 32'(LINE_LEN))
	`TLD_NEVER(a_copy_bound, clk, arst_n, (state_q == S_COPY) && (copy_idx_q > line_len_q))
	`TLD_ASSERT(a_pop_after_read, clk, arst_n, (state_q == S_RDWAIT) |=> !full_q)

endmodule

>>> hw/rtl/terminal_line_discipline.sv
// ----------------------------------------------------------------------------
// terminal_line_discipline
// Terminal input engine with canonical line editing and a cooked byte ring.
// ----------------------------------------------------------------------------
// in_ch carries commands (typed byte, read cooked byte, take signal, take eof);
// out_ch returns one or two result beats per command, the status beat last.
// cfg_ch writes registers 0..6; a write clears the edit line, the pending
// signal and the pending eof, and must only be issued while the block is idle.
// A two-entry classify queue takes new commands while the engine is busy.
// Each accepted command passes from the queue into the engine and ends in the
// status state. A newline or eof that commits a line first runs the copy loop
// from the line RAM into the ring, and a newline then queues itself; a read
// first waits for the ring RAM read.
// The single output register holds a result while out_ch stalls; the engine
// then waits, and the front queue fills and drops in_ch.ready.
// Reset empties the line and ring, clears signal and eof and loads the
// default characters; the RAMs are not cleared.
// ----------------------------------------------------------------------------
module terminal_line_discipline #(
	parameter int LINE_LEN    = 256,
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	tld_in_if.sink    in_ch,
	tld_out_if.source out_ch,
	tld_cfg_if.sink   cfg_ch
);
	import tld_pkg::*;

	cfg_t  cfg;
	logic  clr;
	item_t item;
	logic  item_valid;
	logic  item_pop;

	tld_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg),
		.clr    (clr)
	);

	tld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg        (cfg),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop)
	);

	tld_engine #(
		.LINE_LEN    (LINE_LEN),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clr        (clr),
		.item       (item),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.out_ch     (out_ch)
	);

endmodule

>>> tb/sv/tld_scoreboard.sv
// ----------------------------------------------------------------------------
// tld_scoreboard
// Tracks the line discipline state for accepted commands and checks results.
// ----------------------------------------------------------------------------
package tld_scoreboard_pkg;
	import tld_pkg::*;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] echo_byte;
		logic [8:0] erase_count;
		logic [2:0] status;
		logic [7:0] read_byte;
		logic [1:0] signal_code;
		logic       eof_flag;
		logic       data_ready;
		logic       last;
	} tld_result_t;

	class tld_scoreboard;
		localparam int LINE_LEN    = 256;
		localparam int QUEUE_DEPTH = 1024;

		cfg_t        cfg;
		logic [7:0]  line_buf[LINE_LEN];
		int          line_len;
		logic [7:0]  ring[QUEUE_DEPTH];
		int          head, tail;
		bit          ring_full;
		logic [1:0]  sig_pend;
		bit          eof_pend;
		tld_result_t pending_results[$];
		int          errors;

		function new();
			cfg = '{mode: 4'hF, intr_ch: 8'd3, quit_ch: 8'd28, erase_ch: 8'd127,
				kill_ch: 8'h15, eof_ch: 8'd4, susp_ch: 8'd26};
			line_len = 0;
			head = 0;
			tail = 0;
			ring_full = 0;
			sig_pend = SIG_NONE;
			eof_pend = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [7:0] val);
			case (idx)
				REG_MODE:  cfg.mode = val[3:0];
				REG_INTR:  cfg.intr_ch = val;
				REG_QUIT:  cfg.quit_ch = val;
				REG_ERASE: cfg.erase_ch = val;
				REG_KILL:  cfg.kill_ch = val;
				REG_EOF:   cfg.eof_ch = val;
				REG_SUSP:  cfg.susp_ch = val;
				default: return;
			endcase
			line_len = 0;
			sig_pend = SIG_NONE;
			eof_pend = 0;
		endfunction

		function bit ring_empty();
			return head == tail && !ring_full;
		endfunction

		function void push_cooked(logic [7:0] b);
			if (ring_full)
				return;
			ring[tail] = b;
			tail = (tail + 1) % QUEUE_DEPTH;
			if (tail == head)
				ring_full = 1;
		endfunction

		function void flush_line();
			for (int i = 0; i < line_len; i++)
				push_cooked(line_buf[i]);
			line_len = 0;
		endfunction

		function void add_result(logic [1:0] kind, logic [7:0] eb, logic [8:0] ec);
			tld_result_t r;
			r = '0;
			r.kind = kind;
			r.echo_byte = eb;
			r.erase_count = ec;
			pending_results.push_back(r);
		endfunction

		function void note_command(logic [1:0] cmd, logic [7:0] c);
			tld_result_t r;
			logic [1:0]  sig0;
			bit          eof0;
			logic [2:0]  st;
			logic [7:0]  rb;
			sig0 = sig_pend;
			eof0 = eof_pend;
			st = ST_CONSUMED;
			rb = '0;
			if (cmd == CMD_READ) begin
				if (ring_empty()) begin
					st = ST_EMPTY;
				end else begin
					rb = ring[head];
					head = (head + 1) % QUEUE_DEPTH;
					ring_full = 0;
					st = ST_BYTE_READ;
				end
			end else if (cmd == CMD_TAKE_SIG) begin
				sig_pend = SIG_NONE;
				st = ST_TAKEN;
			end else if (cmd == CMD_TAKE_EOF) begin
				eof_pend = 0;
				st = ST_TAKEN;
			end else if (cfg.mode[MODE_SIG] &&
					(c == cfg.intr_ch || c == cfg.quit_ch || c == cfg.susp_ch)) begin
				sig_pend = (c == cfg.intr_ch) ? SIG_INT :
					(c == cfg.quit_ch) ? SIG_QUIT : SIG_STOP;
				st = ST_SIGNAL;
			end else if (cfg.mode[MODE_CANON]) begin
				if (c == CH_NEWLINE) begin
					flush_line();
					push_cooked(c);
					add_result(KIND_ECHO, c, '0);
					st = ST_LINE_READY;
				end else if (c == cfg.eof_ch) begin
					if (line_len == 0) begin
						eof_pend = 1;
						st = ST_EOF;
					end else begin
						flush_line();
						st = ST_LINE_READY;
					end
				end else if (c == cfg.erase_ch) begin
					if (line_len > 0) begin
						line_len--;
						if (cfg.mode[MODE_VERASE])
							add_result(KIND_ERASE, '0, 9'd1);
					end
				end else if (c == cfg.kill_ch) begin
					if (line_len > 0 && cfg.mode[MODE_VERASE])
						add_result(KIND_ERASE, '0, (line_len > 511) ? ERASE_MAX : 9'(line_len));
					line_len = 0;
				end else if (line_len < LINE_LEN) begin
					line_buf[line_len] = c;
					line_len++;
					if (cfg.mode[MODE_ECHO])
						add_result(KIND_ECHO, c, '0);
				end else begin
					st = ST_OVERFLOW;
				end
			end else begin
				push_cooked(c);
				if (cfg.mode[MODE_ECHO])
					add_result(KIND_ECHO, c, '0);
				st = ST_LINE_READY;
			end
			r = '0;
			r.kind = KIND_STATUS;
			r.status = st;
			r.read_byte = rb;
			r.signal_code = sig0;
			r.eof_flag = eof0;
			r.data_ready = !ring_empty() || eof_pend;
			r.last = 1'b1;
			pending_results.push_back(r);
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch: %s got %0h expected %0h", what, got, want);
			errors++;
		endtask

		task check_result(tld_result_t got);
			tld_result_t want;
			if (pending_results.size() == 0) begin
				report("unexpected beat, kind", 32'(got.kind), 32'd0);
				return;
			end
			want = pending_results.pop_front();
			if (got.kind !== want.kind) report("kind", 32'(got.kind), 32'(want.kind));
			if (got.echo_byte !== want.echo_byte)
				report("echo_byte", 32'(got.echo_byte), 32'(want.echo_byte));
			if (got.erase_count !== want.erase_count)
				report("erase_count", 32'(got.erase_count), 32'(want.erase_count));
			if (got.status !== want.status)
				report("status", 32'(got.status), 32'(want.status));
			if (got.read_byte !== want.read_byte)
				report("read_byte", 32'(got.read_byte), 32'(want.read_byte));
			if (got.signal_code !== want.signal_code)
				report("signal_code", 32'(got.signal_code), 32'(want.signal_code));
			if (got.eof_flag !== want.eof_flag)
				report("eof_flag", 32'(got.eof_flag), 32'(want.eof_flag));
			if (got.data_ready !== want.data_ready)
				report("data_ready", 32'(got.data_ready), 32'(want.data_ready));
			if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
		endtask
	endclass
endpackage

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives commands and register writes into the line discipline under random
// idling and a long output stall, checking every result beat in order.
// ----------------------------------------------------------------------------
module testbench;
	import tld_pkg::*;
	import tld_scoreboard_pkg::*;

	logic clk;
	logic arst_n;

	tld_in_if  in_ch();
	tld_out_if out_ch();
	tld_cfg_if cfg_ch();

	terminal_line_discipline dut (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_ch(cfg_ch.sink)
	);

	tld_scoreboard line_model;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_cycles;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

	// receiver: ready changes on the falling edge, beats sampled at the rising edge
	initial begin
		out_ch.ready = 0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		tld_result_t r;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			r.kind = out_ch.kind;
			r.echo_byte = out_ch.echo_byte;
			r.erase_count = out_ch.erase_count;
			r.status = out_ch.status;
			r.read_byte = out_ch.read_byte;
			r.signal_code = out_ch.signal_code;
			r.eof_flag = out_ch.eof_flag;
			r.data_ready = out_ch.data_ready;
			r.last = out_ch.last;
			line_model.check_result(r);
		end
	end

	// valid stays up after a beat; wait_drained, or an idle in the next call, drops it
	task automatic send_cmd(logic [1:0] cmd, logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 0;
			@(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.cmd <= cmd;
		in_ch.in_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		line_model.note_command(cmd, b);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 0;
		while (line_model.pending_results.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		line_model.write_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic write_all(logic [3:0] mode, logic [7:0] intr, logic [7:0] quit,
			logic [7:0] erase, logic [7:0] kill, logic [7:0] eofc, logic [7:0] susp);
		wait_drained();
		write_reg(REG_MODE, mode);
		write_reg(REG_INTR, intr);
		write_reg(REG_QUIT, quit);
		write_reg(REG_ERASE, erase);
		write_reg(REG_KILL, kill);
		write_reg(REG_EOF, eofc);
		write_reg(REG_SUSP, susp);
		cfg_ch.valid <= 0;
	endtask

	// mostly printable text with the control bytes mixed in
	function automatic logic [7:0] pick_byte();
		cfg_t c;
		c = line_model.cfg;
		case ($urandom_range(19))
			0: return c.intr_ch;
			1: return c.quit_ch;
			2: return c.susp_ch;
			3: return c.erase_ch;
			4: return c.kill_ch;
			5: return c.eof_ch;
			6, 7: return CH_NEWLINE;
			8: return 8'($urandom_range(255));
			default: return 8'($urandom_range(8'h7E, 8'h20));
		endcase
	endfunction

	task automatic random_cmds(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70)
				send_cmd(CMD_TYPED, pick_byte());
			else if (r < 90)
				send_cmd(CMD_READ, 8'($urandom_range(255)));
			else if (r < 95)
				send_cmd(CMD_TAKE_SIG, 8'($urandom_range(255)));
			else
				send_cmd(CMD_TAKE_EOF, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		line_model = new();
		send_idle_pct = 10;
		recv_idle_pct = 74;
		hold_cycles = 0;
		in_ch.valid = 0;
		in_ch.cmd = CMD_TYPED;
		in_ch.in_byte = 0;
		cfg_ch.valid = 0;
		cfg_ch.index = REG_MODE;
		cfg_ch.data = 0;
		arst_n = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: defaults, every command and special case
		send_cmd(CMD_READ, 8'h00);
		send_cmd(CMD_TYPED, 8'h03);
		send_cmd(CMD_TYPED, 8'h1C);
		send_cmd(CMD_TYPED, 8'h1A);
		send_cmd(CMD_TAKE_SIG, 8'hFF);
		send_cmd(CMD_TYPED, 8'h7F);
		send_cmd(CMD_TYPED, 8'h04);
		send_cmd(CMD_TAKE_EOF, 8'h00);
		send_cmd(CMD_TYPED, 8'h41);
		send_cmd(CMD_TYPED, 8'hFF);
		send_cmd(CMD_TYPED, 8'h00);
		send_cmd(CMD_TYPED, 8'h7F);
		send_cmd(CMD_TYPED, 8'h42);
		send_cmd(CMD_TYPED, 8'h15);
		send_cmd(CMD_TYPED, 8'h43);
		send_cmd(CMD_TYPED, 8'h04);
		send_cmd(CMD_TYPED, 8'h44);
		send_cmd(CMD_TYPED, CH_NEWLINE);
		send_cmd(CMD_READ, 8'h00);
		send_cmd(CMD_READ, 8'h00);
		send_cmd(CMD_READ, 8'h00);

		// line overflow then kill of a full line
		for (int i = 0; i < 258; i++)
			send_cmd(CMD_TYPED, 8'($urandom_range(8'h7E, 8'h30)));
		send_cmd(CMD_TYPED, 8'h15);

		// fill the ring past full with committed lines
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 256; i++)
				send_cmd(CMD_TYPED, 8'($urandom_range(8'h7E, 8'h30)));
			send_cmd(CMD_TYPED, CH_NEWLINE);
		end
		send_cmd(CMD_TYPED, 8'h04);
		for (int i = 0; i < 30; i++)
			send_cmd(CMD_READ, 8'h00);

		// long output stall while commands keep coming
		wait_drained();
		hold_cycles = 400;
		random_cmds(20);

		random_cmds(80);

		write_all(4'h0, 8'h00, 8'hFF, 8'h08, 8'h18, 8'hFF, 8'h80);
		random_cmds(60);
		write_all(4'hF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h0A, 8'h11);
		random_cmds(60);

		send_idle_pct = 74;
		recv_idle_pct = 10;
		write_all(4'h3, 8'h03, 8'h1C, 8'h7F, 8'h15, 8'h04, 8'h1A);
		random_cmds(80);
		write_all(4'h6, 8'h55, 8'hAA, 8'h0A, 8'h08, 8'h04, 8'h1A);
		random_cmds(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all(4'hD, 8'h03, 8'h03, 8'h7F, 8'h7F, 8'h04, 8'h03);
		random_cmds(60);
		write_all(4'hF, 8'h03, 8'h1C, 8'h7F, 8'h15, 8'h04, 8'h1A);
		random_cmds(120);

		wait_drained();
		if (line_model.errors == 0 && line_model.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/tld_pkg.sv
hw/rtl/tld_if.sv
hw/rtl/tld_regs.sv
hw/rtl/tld_front.sv
hw/rtl/tld_engine.sv
hw/rtl/terminal_line_discipline.sv
tb/sv/tld_scoreboard.sv
tb/sv/testbench.sv
